FILE: design/arx_pkg.sv
package arx_pkg;

    localparam int MAX_ORDER = 8;
    localparam int MAX_DELAY = 16;

    // Field widths of the item and of the registers.
    localparam int KIND_W      = 2;
    localparam int DATA_W      = 32;
    localparam int COEF_W      = 20;
    localparam int CIDX_W      = 3;
    localparam int FRAC_W      = 16;
    localparam int ORD_FIELD_W = 4;
    localparam int DLY_FIELD_W = 5;

    // Configuration port.
    localparam int NUM_REGS  = 3;
    localparam int PDATA_W   = 32;
    localparam int ADDR_W    = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_W = ADDR_W - 2;

    // Internal widths that follow from the depths.
    localparam int ORDER_W = $clog2(MAX_ORDER + 1);
    localparam int DLY_W   = $clog2(MAX_DELAY + 1);
    localparam int ORD_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DIDX_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CNT_W   = $clog2(2 * MAX_ORDER + 1);
    localparam int PROD_W  = DATA_W + COEF_W;
    localparam int ACC_W   = PROD_W + CNT_W + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_LOAD_A = 2'd1,
        KIND_LOAD_B = 2'd2,
        KIND_CLEAR  = 2'd3
    } arx_kind_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_A_ORDER = 2'd0,
        REG_B_ORDER = 2'd1,
        REG_DELAY   = 2'd2
    } arx_reg_idx_t;

    typedef struct packed {
        logic [ORDER_W-1:0] a_order;
        logic [ORDER_W-1:0] b_order;
        logic [DLY_W-1:0]   delay;
    } arx_cfg_t;

    // One-cycle pulses that trim a history after its length was rewritten.
    typedef struct packed {
        logic trim_a;
        logic trim_b;
        logic trim_d;
    } arx_trim_t;

    typedef struct packed {
        logic             shift;
        logic             issue;
        logic [CNT_W-1:0] term;
        logic             round;
        logic             wb;
    } arx_cmd_t;

    typedef struct packed {
        logic out_busy;
    } arx_stat_t;

    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORD_FIELD_W-1:0] v);
        if (int'(v) > MAX_ORDER)
            return ORDER_W'(MAX_ORDER);
        else
            return ORDER_W'(v);
    endfunction

    function automatic logic [DLY_W-1:0] clamp_delay(input logic [DLY_FIELD_W-1:0] v);
        if (int'(v) < 1)
            return DLY_W'(1);
        else if (int'(v) > MAX_DELAY)
            return DLY_W'(MAX_DELAY);
        else
            return DLY_W'(v);
    endfunction

endpackage

FILE: design/arx_in_if.sv
interface arx_in_if;
    logic                                valid;
    logic                                ready;
    logic [arx_pkg::KIND_W-1:0]          kind;
    logic signed [arx_pkg::DATA_W-1:0]   sample_in;
    logic signed [arx_pkg::DATA_W-1:0]   noise_in;
    logic [arx_pkg::CIDX_W-1:0]          coef_index;
    logic signed [arx_pkg::COEF_W-1:0]   coef_value;

    modport source (output valid, kind, sample_in, noise_in, coef_index, coef_value,
                    input ready);
    modport sink (input valid, kind, sample_in, noise_in, coef_index, coef_value,
                  output ready);
endinterface

FILE: design/arx_out_if.sv
interface arx_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [arx_pkg::DATA_W-1:0]   model_out;
    logic                                saturated;

    modport source (output valid, model_out, saturated, input ready);
    modport sink (input valid, model_out, saturated, output ready);
endinterface

FILE: design/arx_regs.sv
module arx_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arx_pkg::ADDR_W-1:0]   paddr,
    input  logic [arx_pkg::PDATA_W-1:0]  pwdata,
    output logic [arx_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output arx_pkg::arx_cfg_t            cfg,
    output arx_pkg::arx_trim_t           trim
);

    arx_pkg::arx_cfg_t     cfg_reg;
    arx_pkg::arx_cfg_t     cfg_next;
    arx_pkg::arx_trim_t    trim_reg;
    arx_pkg::arx_trim_t    trim_next;
    arx_pkg::arx_reg_idx_t reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = arx_pkg::arx_reg_idx_t'(paddr[arx_pkg::ADDR_W-1:2]);

    always_comb
    begin
        cfg_next  = cfg_reg;
        trim_next = '0;
        if (wr_en)
        begin
            unique case (reg_idx)
                arx_pkg::REG_A_ORDER:
                begin
                    cfg_next.a_order = arx_pkg::clamp_order(pwdata[arx_pkg::ORD_FIELD_W-1:0]);
                    trim_next.trim_a = 1'b1;
                end
                arx_pkg::REG_B_ORDER:
                begin
                    cfg_next.b_order = arx_pkg::clamp_order(pwdata[arx_pkg::ORD_FIELD_W-1:0]);
                    trim_next.trim_b = 1'b1;
                end
                arx_pkg::REG_DELAY:
                begin
                    cfg_next.delay   = arx_pkg::clamp_delay(pwdata[arx_pkg::DLY_FIELD_W-1:0]);
                    trim_next.trim_d = 1'b1;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            arx_pkg::REG_A_ORDER: prdata = arx_pkg::PDATA_W'(cfg_reg.a_order);
            arx_pkg::REG_B_ORDER: prdata = arx_pkg::PDATA_W'(cfg_reg.b_order);
            arx_pkg::REG_DELAY:   prdata = arx_pkg::PDATA_W'(cfg_reg.delay);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a_order <= '0;
            cfg_reg.b_order <= '0;
            cfg_reg.delay   <= arx_pkg::DLY_W'(1);
            trim_reg        <= '0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            trim_reg <= trim_next;
        end
    end

    assign cfg  = cfg_reg;
    assign trim = trim_reg;

endmodule

FILE: design/arx_ctrl.sv
module arx_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_fire,
    input  logic [arx_pkg::KIND_W-1:0] in_kind,
    input  arx_pkg::arx_cfg_t     cfg,
    input  arx_pkg::arx_stat_t    stat,
    output logic                  in_ready,
    output arx_pkg::arx_cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SHIFT = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_WB    = 5'b10000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [arx_pkg::CNT_W-1:0] cnt_reg;
    logic [arx_pkg::CNT_W-1:0] cnt_next;
    logic [arx_pkg::CNT_W-1:0] n_terms;

    assign n_terms = arx_pkg::CNT_W'(cfg.a_order) + arx_pkg::CNT_W'(cfg.b_order);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.term   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && (arx_pkg::arx_kind_t'(in_kind) == arx_pkg::KIND_SAMPLE))
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // The last product lands in the accumulator in the cycle
                // after its issue, which is the cycle with the count at n.
                if (cnt_reg < n_terms)
                begin
                    cmd.issue = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (!stat.out_busy)
                begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_mac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (cnt_reg <= n_terms))
        else $error("term count ran past the number of terms");

    a_shift_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |=> ((state_reg == ST_MAC) && (cnt_reg == '0)))
        else $error("shift step not followed by a fresh accumulation");

    a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WB) && stat.out_busy) |=> (state_reg == ST_WB))
        else $error("result written while the output register was still full");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid) |-> !(cmd.shift || cmd.issue || cmd.round || cmd.wb))
        else $error("datapath command issued while taking a new item");
`endif

endmodule

FILE: design/arx_dp.sv
module arx_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_fire,
    input  logic [arx_pkg::KIND_W-1:0]         in_kind,
    input  logic signed [arx_pkg::DATA_W-1:0]  in_sample,
    input  logic signed [arx_pkg::DATA_W-1:0]  in_noise,
    input  logic [arx_pkg::CIDX_W-1:0]         in_coef_index,
    input  logic signed [arx_pkg::COEF_W-1:0]  in_coef_value,
    input  arx_pkg::arx_cfg_t                  cfg,
    input  arx_pkg::arx_trim_t                 trim,
    input  arx_pkg::arx_cmd_t                  cmd,
    output arx_pkg::arx_stat_t                 stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [arx_pkg::DATA_W-1:0]  out_data,
    output logic                               out_sat
);

    localparam int QHI = arx_pkg::FRAC_W + arx_pkg::DATA_W - 1;

    logic signed [arx_pkg::DATA_W-1:0] dly_reg  [arx_pkg::MAX_DELAY];
    logic signed [arx_pkg::DATA_W-1:0] hin_reg  [arx_pkg::MAX_ORDER];
    logic signed [arx_pkg::DATA_W-1:0] hout_reg [arx_pkg::MAX_ORDER];
    logic signed [arx_pkg::COEF_W-1:0] acoef_reg [arx_pkg::MAX_ORDER];
    logic signed [arx_pkg::COEF_W-1:0] bcoef_reg [arx_pkg::MAX_ORDER];

    logic signed [arx_pkg::DATA_W-1:0] sample_reg;
    logic signed [arx_pkg::DATA_W-1:0] noise_reg;
    logic signed [arx_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_sub_reg;
    logic                              prod_vld_reg;
    logic signed [arx_pkg::ACC_W-1:0]  acc_reg;
    logic signed [arx_pkg::DATA_W-1:0] res_reg;
    logic                              res_sat_reg;
    logic signed [arx_pkg::DATA_W-1:0] out_data_reg;
    logic                              out_sat_reg;
    logic                              out_vld_reg;

    arx_pkg::arx_kind_t                kind;
    logic signed [arx_pkg::DATA_W-1:0] leaving;
    logic [arx_pkg::DIDX_W-1:0]        leave_idx;
    logic [arx_pkg::DLY_W-1:0]         leave_pos;
    logic                              term_sub;
    logic [arx_pkg::CNT_W-1:0]         term_a;
    logic [arx_pkg::ORD_W-1:0]         sel_idx;
    logic signed [arx_pkg::COEF_W-1:0] sel_coef;
    logic signed [arx_pkg::DATA_W-1:0] sel_hist;
    logic signed [arx_pkg::ACC_W-1:0]  prod_ext;
    logic signed [arx_pkg::ACC_W-1:0]  noise_ext;
    logic signed [arx_pkg::ACC_W-1:0]  rnd;
    logic                              in_range;
    logic signed [arx_pkg::DATA_W-1:0] rnd_q;

    assign kind      = arx_pkg::arx_kind_t'(in_kind);
    assign leave_pos = cfg.delay - 1'b1;
    assign leave_idx = leave_pos[arx_pkg::DIDX_W-1:0];
    assign leaving   = dly_reg[leave_idx];

    // Terms below b_order use the input history, the rest the output history.
    assign term_sub = (cmd.term >= arx_pkg::CNT_W'(cfg.b_order));
    assign term_a   = cmd.term - arx_pkg::CNT_W'(cfg.b_order);
    assign sel_idx  = term_sub ? term_a[arx_pkg::ORD_W-1:0] : cmd.term[arx_pkg::ORD_W-1:0];
    assign sel_coef = term_sub ? acoef_reg[sel_idx] : bcoef_reg[sel_idx];
    assign sel_hist = term_sub ? hout_reg[sel_idx] : hin_reg[sel_idx];

    assign prod_ext  = {{(arx_pkg::ACC_W-arx_pkg::PROD_W){prod_reg[arx_pkg::PROD_W-1]}},
                        prod_reg};
    assign noise_ext = {{(arx_pkg::ACC_W-arx_pkg::DATA_W-arx_pkg::FRAC_W)
                         {noise_reg[arx_pkg::DATA_W-1]}},
                        noise_reg, {arx_pkg::FRAC_W{1'b0}}};

    // Adding one half and dropping the fraction rounds ties upward.
    assign rnd      = acc_reg + (arx_pkg::ACC_W'(1) <<< (arx_pkg::FRAC_W - 1));
    assign in_range = (&rnd[arx_pkg::ACC_W-1:QHI]) || !(|rnd[arx_pkg::ACC_W-1:QHI]);
    assign rnd_q    = rnd[QHI:arx_pkg::FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < arx_pkg::MAX_DELAY; i++)
                dly_reg[i] <= '0;
            for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
            begin
                hin_reg[i]   <= '0;
                hout_reg[i]  <= '0;
                acoef_reg[i] <= '0;
                bcoef_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_fire)
            begin
                unique case (kind)
                    arx_pkg::KIND_SAMPLE:
                    begin
                    end
                    arx_pkg::KIND_LOAD_A:
                    begin
                        for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                            if (int'(in_coef_index) == i)
                                acoef_reg[i] <= in_coef_value;
                    end
                    arx_pkg::KIND_LOAD_B:
                    begin
                        for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                            if (int'(in_coef_index) == i)
                                bcoef_reg[i] <= in_coef_value;
                    end
                    arx_pkg::KIND_CLEAR:
                    begin
                        for (int i = 0; i < arx_pkg::MAX_DELAY; i++)
                            dly_reg[i] <= '0;
                        for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                        begin
                            hin_reg[i]  <= '0;
                            hout_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Only the entries inside the current length move.
            if (cmd.shift)
            begin
                for (int i = 0; i < arx_pkg::MAX_DELAY; i++)
                    if (i < int'(cfg.delay))
                        dly_reg[i] <= (i == 0) ? sample_reg : dly_reg[(i == 0) ? 0 : i - 1];
                for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                    if (i < int'(cfg.b_order))
                        hin_reg[i] <= (i == 0) ? leaving : hin_reg[(i == 0) ? 0 : i - 1];
            end

            if (cmd.wb)
            begin
                for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                    if (i < int'(cfg.a_order))
                        hout_reg[i] <= (i == 0) ? res_reg : hout_reg[(i == 0) ? 0 : i - 1];
            end

            if (trim.trim_d)
                for (int i = 0; i < arx_pkg::MAX_DELAY; i++)
                    if (i >= int'(cfg.delay))
                        dly_reg[i] <= '0;
            if (trim.trim_b)
                for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                    if (i >= int'(cfg.b_order))
                        hin_reg[i] <= '0;
            if (trim.trim_a)
                for (int i = 0; i < arx_pkg::MAX_ORDER; i++)
                    if (i >= int'(cfg.a_order))
                        hout_reg[i] <= '0;
        end
    end

    // Payload registers of the multiply-accumulate path.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= in_sample;
            noise_reg  <= in_noise;
        end
        if (cmd.issue)
        begin
            prod_reg     <= sel_coef * sel_hist;
            prod_sub_reg <= term_sub;
        end
        if (cmd.shift)
            acc_reg <= noise_ext;
        else if (prod_vld_reg)
            acc_reg <= prod_sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        if (cmd.round)
        begin
            res_sat_reg <= !in_range;
            if (in_range)
                res_reg <= rnd_q;
            else
                res_reg <= rnd[arx_pkg::ACC_W-1] ? {1'b1, {(arx_pkg::DATA_W-1){1'b0}}}
                                                 : {1'b0, {(arx_pkg::DATA_W-1){1'b1}}};
        end
        if (cmd.wb)
        begin
            out_data_reg <= res_reg;
            out_sat_reg  <= res_sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.issue;
            if (cmd.wb)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    assign stat.out_busy = out_vld_reg && !out_ready;
    assign out_valid     = out_vld_reg;
    assign out_data      = out_data_reg;
    assign out_sat       = out_sat_reg;

endmodule

FILE: design/arx_model_step.sv
// One ARX model step per sample item: the sample goes through a transport
// delay line, the value leaving it enters the input history, and the output
// is the b-weighted input history minus the a-weighted output history plus
// the noise value, rounded to Q16.16 and saturated. All terms of a sample
// item go one per cycle through a single shared 32 x 20 multiplier and
// accumulator; the next item is accepted as soon as the result is in the
// output register. Coefficient loads and clear items give no result and
// keep the block ready for the next item. Registers: a_order at 0x0,
// b_order at 0x4, transport_delay at 0x8; writing a length zeros the
// history entries beyond it.
module arx_model_step (
    input  logic                         clk,
    input  logic                         rst_n,
    arx_in_if.sink                       in_ch,
    arx_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arx_pkg::ADDR_W-1:0]   paddr,
    input  logic [arx_pkg::PDATA_W-1:0]  pwdata,
    output logic [arx_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    arx_pkg::arx_cfg_t  cfg;
    arx_pkg::arx_trim_t trim;
    arx_pkg::arx_cmd_t  cmd;
    arx_pkg::arx_stat_t stat;
    logic               in_ready;
    logic               in_fire;

    assign in_ch.ready = in_ready;
    assign in_fire     = in_ch.valid && in_ready;

    arx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .trim    (trim)
    );

    arx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_fire  (in_fire),
        .in_kind  (in_ch.kind),
        .cfg      (cfg),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    arx_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .in_kind       (in_ch.kind),
        .in_sample     (in_ch.sample_in),
        .in_noise      (in_ch.noise_in),
        .in_coef_index (in_ch.coef_index),
        .in_coef_value (in_ch.coef_value),
        .cfg           (cfg),
        .trim          (trim),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_data      (out_ch.model_out),
        .out_sat       (out_ch.saturated)
    );

endmodule

FILE: tb/sv/arx_model_step_tb.sv
`timescale 1ns / 100ps

module arx_model_step_tb;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASES = 8;
    localparam int LOADS_PER_PHASE = 16;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int PHASE_A[5] = '{8, 0, 15, 1, 8};
    localparam int PHASE_B[5] = '{8, 0, 9, 8, 1};
    localparam int PHASE_D[5] = '{16, 1, 31, 0, 17};

    localparam logic signed [arx_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [arx_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [arx_pkg::COEF_W-1:0] COEF_MAX = 20'sh7FFFF;
    localparam logic signed [arx_pkg::COEF_W-1:0] COEF_MIN = 20'sh80000;
    localparam logic signed [arx_pkg::COEF_W-1:0] COEF_ONE = 20'sh10000;
    localparam logic signed [arx_pkg::COEF_W-1:0] COEF_ZERO = 20'sh00000;

    typedef struct {
        arx_pkg::arx_kind_t                 kind;
        logic signed [arx_pkg::DATA_W-1:0]  sample;
        logic signed [arx_pkg::DATA_W-1:0]  noise;
        logic [arx_pkg::CIDX_W-1:0]         idx;
        logic signed [arx_pkg::COEF_W-1:0]  coef;
    } arx_item_t;

    typedef struct {
        logic signed [arx_pkg::DATA_W-1:0] y;
        logic                              sat;
    } arx_y_t;

    // Tracks the model state and holds the outputs still owed by the block.
    class arx_model_tracker;
        arx_y_t                            y_queue[$];
        int                                errors;
        int                                a_len;
        int                                b_len;
        int                                dly_len;
        logic signed [arx_pkg::DATA_W-1:0] dline[arx_pkg::MAX_DELAY];
        logic signed [arx_pkg::DATA_W-1:0] hist_u[arx_pkg::MAX_ORDER];
        logic signed [arx_pkg::DATA_W-1:0] hist_y[arx_pkg::MAX_ORDER];
        logic signed [arx_pkg::COEF_W-1:0] coef_a[arx_pkg::MAX_ORDER];
        logic signed [arx_pkg::COEF_W-1:0] coef_b[arx_pkg::MAX_ORDER];

        function new();
            errors = 0;
            a_len = 0;
            b_len = 0;
            dly_len = 1;
            foreach (dline[i]) dline[i] = '0;
            foreach (hist_u[i])
            begin
                hist_u[i] = '0;
                hist_y[i] = '0;
                coef_a[i] = '0;
                coef_b[i] = '0;
            end
        endfunction

        function int pending();
            return y_queue.size();
        endfunction

        function void apply_register(arx_pkg::arx_reg_idx_t r,
                                     logic [arx_pkg::PDATA_W-1:0] value);
            int v;
            case (r)
                arx_pkg::REG_A_ORDER:
                begin
                    v = int'(value[3:0]);
                    a_len = (v > arx_pkg::MAX_ORDER) ? arx_pkg::MAX_ORDER : v;
                    for (int i = a_len; i < arx_pkg::MAX_ORDER; i++) hist_y[i] = '0;
                end
                arx_pkg::REG_B_ORDER:
                begin
                    v = int'(value[3:0]);
                    b_len = (v > arx_pkg::MAX_ORDER) ? arx_pkg::MAX_ORDER : v;
                    for (int i = b_len; i < arx_pkg::MAX_ORDER; i++) hist_u[i] = '0;
                end
                arx_pkg::REG_DELAY:
                begin
                    v = int'(value[4:0]);
                    dly_len = (v < 1) ? 1 :
                              ((v > arx_pkg::MAX_DELAY) ? arx_pkg::MAX_DELAY : v);
                    for (int i = dly_len; i < arx_pkg::MAX_DELAY; i++) dline[i] = '0;
                end
                default: ;
            endcase
        endfunction

        // One model step for an accepted item; a sample item owes one output.
        function void accept_item(arx_item_t it);
            logic signed [arx_pkg::DATA_W-1:0] leaving;
            longint acc;
            longint q;
            arx_y_t res;
            case (it.kind)
                arx_pkg::KIND_LOAD_A: coef_a[it.idx] = it.coef;
                arx_pkg::KIND_LOAD_B: coef_b[it.idx] = it.coef;
                arx_pkg::KIND_CLEAR:
                begin
                    foreach (dline[i]) dline[i] = '0;
                    foreach (hist_u[i])
                    begin
                        hist_u[i] = '0;
                        hist_y[i] = '0;
                    end
                end
                default:
                begin
                    leaving = dline[dly_len-1];
                    for (int i = dly_len - 1; i > 0; i--) dline[i] = dline[i-1];
                    dline[0] = it.sample;
                    if (b_len > 0)
                    begin
                        for (int i = b_len - 1; i > 0; i--) hist_u[i] = hist_u[i-1];
                        hist_u[0] = leaving;
                    end
                    acc = longint'(it.noise) <<< arx_pkg::FRAC_W;
                    for (int i = 0; i < b_len; i++)
                        acc += longint'(coef_b[i]) * longint'(hist_u[i]);
                    for (int i = 0; i < a_len; i++)
                        acc -= longint'(coef_a[i]) * longint'(hist_y[i]);
                    // Add half an LSB, then floor: ties go toward plus infinity.
                    q = (acc + 64'sd32768) >>> arx_pkg::FRAC_W;
                    res.sat = 1'b0;
                    if (q > longint'(WORD_MAX))
                    begin
                        q = longint'(WORD_MAX);
                        res.sat = 1'b1;
                    end
                    else if (q < longint'(WORD_MIN))
                    begin
                        q = longint'(WORD_MIN);
                        res.sat = 1'b1;
                    end
                    res.y = q[arx_pkg::DATA_W-1:0];
                    if (a_len > 0)
                    begin
                        for (int i = a_len - 1; i > 0; i--) hist_y[i] = hist_y[i-1];
                        hist_y[0] = res.y;
                    end
                    y_queue.push_back(res);
                end
            endcase
        endfunction

        function void compare_output(logic signed [arx_pkg::DATA_W-1:0] y, logic sat);
            arx_y_t exp_y;
            if (y_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: output with none pending: model_out=%h saturated=%b",
                             $realtime, y, sat);
                return;
            end
            exp_y = y_queue.pop_front();
            if (y !== exp_y.y || sat !== exp_y.sat)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: model_out exp %h got %h, saturated exp %b got %b",
                             $realtime, exp_y.y, y, exp_y.sat, sat);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [arx_pkg::ADDR_W-1:0] paddr;
    logic [arx_pkg::PDATA_W-1:0] pwdata;
    logic [arx_pkg::PDATA_W-1:0] prdata;
    logic pready;
    bit calm;
    int stall_cycles;

    arx_in_if in_ch();
    arx_out_if out_ch();
    arx_model_tracker tracker = new();

    arx_model_step uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            tracker.accept_item('{arx_pkg::arx_kind_t'(in_ch.kind), in_ch.sample_in,
                                  in_ch.noise_in, in_ch.coef_index, in_ch.coef_value});
        if (out_ch.valid && out_ch.ready)
            tracker.compare_output(out_ch.model_out, out_ch.saturated);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic arx_item_t make_item(arx_pkg::arx_kind_t kind,
                                            logic signed [arx_pkg::DATA_W-1:0] sample,
                                            logic signed [arx_pkg::DATA_W-1:0] noise,
                                            logic [arx_pkg::CIDX_W-1:0] idx,
                                            logic signed [arx_pkg::COEF_W-1:0] coef);
        arx_item_t it;
        it.kind = kind;
        it.sample = sample;
        it.noise = noise;
        it.idx = idx;
        it.coef = coef;
        return it;
    endfunction

    // Half the values of moderate size, some full range, some at the edges.
    function automatic logic signed [arx_pkg::DATA_W-1:0] rand_word(int small_bits);
        logic signed [arx_pkg::DATA_W-1:0] w;
        int pick;
        w = $urandom;
        pick = $urandom_range(9);
        if (pick < 5)
            w = w >>> (arx_pkg::DATA_W - small_bits);
        else if (pick >= 8)
            case ($urandom_range(4))
                0: w = WORD_MAX;
                1: w = WORD_MIN;
                2: w = '0;
                3: w = -1;
                default: w = 1;
            endcase
        return w;
    endfunction

    // Small coefficients keep the feedback loop mostly stable.
    function automatic logic signed [arx_pkg::COEF_W-1:0] rand_coef();
        logic signed [arx_pkg::COEF_W-1:0] c;
        int pick;
        c = arx_pkg::COEF_W'($urandom);
        pick = $urandom_range(19);
        if (pick < 14)
            c = c >>> 6;
        else if (pick >= 17)
            case ($urandom_range(3))
                0: c = COEF_MAX;
                1: c = COEF_MIN;
                2: c = COEF_ONE;
                default: c = -COEF_ONE;
            endcase
        return c;
    endfunction

    function automatic arx_item_t rand_item();
        int pick;
        arx_pkg::arx_kind_t kind;
        pick = $urandom_range(99);
        if (pick < 84)
            kind = arx_pkg::KIND_SAMPLE;
        else if (pick < 91)
            kind = arx_pkg::KIND_LOAD_A;
        else if (pick < 98)
            kind = arx_pkg::KIND_LOAD_B;
        else
            kind = arx_pkg::KIND_CLEAR;
        return make_item(kind, rand_word(21), rand_word(17),
                         arx_pkg::CIDX_W'($urandom_range(arx_pkg::MAX_ORDER - 1)),
                         rand_coef());
    endfunction

    task automatic release_input();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input arx_item_t it);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 11)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= it.kind;
        in_ch.sample_in <= it.sample;
        in_ch.noise_in <= it.noise;
        in_ch.coef_index <= it.idx;
        in_ch.coef_value <= it.coef;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain_outputs();
        release_input();
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(input arx_pkg::arx_reg_idx_t r,
                                  input logic [arx_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.apply_register(r, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Registers change only once the block has gone quiet. Upper data bits
    // are random, since only the low field bits matter.
    task automatic set_lengths(input int a_raw, input int b_raw, input int d_raw);
        logic [arx_pkg::PDATA_W-1:0] junk;
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);
        junk = $urandom;
        write_register(arx_pkg::REG_A_ORDER, {junk[31:4], 4'(a_raw)});
        junk = $urandom;
        write_register(arx_pkg::REG_B_ORDER, {junk[31:4], 4'(b_raw)});
        junk = $urandom;
        write_register(arx_pkg::REG_DELAY, {junk[31:5], 5'(d_raw)});
    endtask

    initial
    begin
        int a_raw;
        int b_raw;
        int d_raw;
        rst_n = 1'b0;
        calm = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = arx_pkg::KIND_SAMPLE;
        in_ch.sample_in = '0;
        in_ch.noise_in = '0;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With both orders at zero the output is the noise alone.
        send_item(make_item(arx_pkg::KIND_SAMPLE, WORD_MAX, WORD_MAX, 3'd0, COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_SAMPLE, WORD_MIN, WORD_MIN, 3'd0, COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_SAMPLE, 32'sh0001_8000, 0, 3'd0, COEF_ZERO));

        // Full orders with a zero delay, which acts as a delay of one.
        set_lengths(arx_pkg::MAX_ORDER, arx_pkg::MAX_ORDER, 0);
        send_item(make_item(arx_pkg::KIND_LOAD_B, 0, 0, 3'd0, COEF_MAX));
        send_item(make_item(arx_pkg::KIND_LOAD_B, 0, 0, 3'd7, COEF_MIN));
        send_item(make_item(arx_pkg::KIND_LOAD_B, 0, 0, 3'd3, COEF_ONE));
        send_item(make_item(arx_pkg::KIND_LOAD_A, 0, 0, 3'd0, COEF_ONE));
        send_item(make_item(arx_pkg::KIND_LOAD_A, 0, 0, 3'd7, COEF_MIN));
        repeat (4)
            send_item(make_item(arx_pkg::KIND_SAMPLE, WORD_MAX, WORD_MAX, 3'd0, COEF_ZERO));
        repeat (2)
            send_item(make_item(arx_pkg::KIND_SAMPLE, WORD_MIN, WORD_MIN, 3'd0, COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_SAMPLE, 1, -1, 3'd0, COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_CLEAR, WORD_MAX, WORD_MAX, 3'd7, COEF_MAX));
        send_item(make_item(arx_pkg::KIND_SAMPLE, 0, 0, 3'd0, COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_LOAD_A, 0, 0, 3'd0, 20'sh08000));
        send_item(make_item(arx_pkg::KIND_SAMPLE, -1, 32'sh0000_8000, 3'd0, COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_SAMPLE, 32'sh0000_0001, 32'sh7FFF_8000, 3'd0,
                            COEF_ZERO));
        send_item(make_item(arx_pkg::KIND_SAMPLE, 32'sh1234_5678, -32'sh0000_8000, 3'd0,
                            COEF_ZERO));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 5)
            begin
                a_raw = PHASE_A[p];
                b_raw = PHASE_B[p];
                d_raw = PHASE_D[p];
            end
            else
            begin
                a_raw = $urandom_range(15);
                b_raw = $urandom_range(15);
                d_raw = $urandom_range(31);
            end
            set_lengths(a_raw, b_raw, d_raw);
            calm = (p == 2);
            for (int k = 0; k < LOADS_PER_PHASE; k++)
                send_item(make_item((k < arx_pkg::MAX_ORDER) ? arx_pkg::KIND_LOAD_A
                                                             : arx_pkg::KIND_LOAD_B,
                                    rand_word(32), rand_word(32),
                                    arx_pkg::CIDX_W'(k % arx_pkg::MAX_ORDER),
                                    rand_coef()));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 3 && n == ITEMS_PER_PHASE / 2)
                    drain_outputs();
                send_item(rand_item());
            end
        end
        calm = 1'b0;

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
